/* src/lztd_pkg.sv */
// Shared constants, types and state codes of the LZ77 token decoder.
`default_nettype none

package lztd_pkg;

	// History depth in bytes; must be a power of two so that the ring index
	// is the low bits of the stream position.
	localparam int unsigned HIST_DEPTH = 4096;
	localparam int unsigned HIST_AW = $clog2(HIST_DEPTH);

	// Token field widths.
	localparam int unsigned DIST_W = 12;
	localparam int unsigned LEN_W = 4;
	localparam int unsigned BYTE_W = 8;

	// Byte counter and capacity register width.
	localparam int unsigned CNT_W = 32;

	// Shortest copy; the length code adds to it.
	localparam int unsigned MIN_MATCH = 3;

	// Copy run counter holds up to the longest copy, fifteen plus three.
	localparam int unsigned RUN_W = 5;

	localparam logic [CNT_W-1:0] CAP_RESET = '1;

	// Classified token as it travels from the front to the back.
	typedef struct packed {
		logic              start;
		logic              copy_ok;
		logic [RUN_W-1:0]  copy_len;
		logic [DIST_W-1:0] back_dist;
		logic [BYTE_W-1:0] lit;
	} cmd_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CHECK,
		BK_COPY,
		BK_LIT
	} back_state_t;

	// Status that the back end reports to the top level.
	typedef struct packed {
		logic busy;
		logic pop;
	} back_stat_t;

endpackage

`default_nettype wire

/* src/lztd_tok_if.sv */
// Token channel: valid/ready handshake carrying one LZ77 token per beat.
`default_nettype none

interface lztd_tok_if;
	logic                              valid;
	logic                              ready;
	logic                              start_of_stream;
	logic [lztd_pkg::DIST_W-1:0]       back_distance;
	logic [lztd_pkg::LEN_W-1:0]        length_code;
	logic [lztd_pkg::BYTE_W-1:0]       literal_byte;

	modport source (
		output valid, start_of_stream, back_distance, length_code, literal_byte,
		input  ready
	);

	modport sink (
		input  valid, start_of_stream, back_distance, length_code, literal_byte,
		output ready
	);
endinterface

`default_nettype wire

/* src/lztd_byte_if.sv */
// Byte channel: valid/ready handshake carrying one decoded byte per beat.
`default_nettype none

interface lztd_byte_if;
	logic                        valid;
	logic                        ready;
	logic [lztd_pkg::BYTE_W-1:0] out_byte;
	logic                        run_last;

	modport source (
		output valid, out_byte, run_last,
		input  ready
	);

	modport sink (
		input  valid, out_byte, run_last,
		output ready
	);
endinterface

`default_nettype wire

/* src/lztd_front.sv */
// Front end: accepts tokens and classifies them into back end commands.
`default_nettype none

module lztd_front (
	lztd_tok_if.sink          token_ch,
	input  wire logic         q_full,
	output lztd_pkg::cmd_t    push_cmd,
	output logic              push
);

	localparam logic [lztd_pkg::CNT_W-1:0] DEPTH_C =
		lztd_pkg::CNT_W'(lztd_pkg::HIST_DEPTH);

	logic [lztd_pkg::CNT_W-1:0] dist_ext;

	// A beat is taken whenever the queue has room.
	assign token_ch.ready = !q_full;
	assign push = token_ch.valid && !q_full;

	assign dist_ext = lztd_pkg::CNT_W'(token_ch.back_distance);

	// A copy is possible only for a nonzero distance inside the history; the
	// check against bytes already produced is left to the back end.
	always_comb begin
		push_cmd.start     = token_ch.start_of_stream;
		push_cmd.copy_ok   = (token_ch.back_distance != '0) && (dist_ext <= DEPTH_C);
		push_cmd.copy_len  = lztd_pkg::RUN_W'(token_ch.length_code)
			+ lztd_pkg::RUN_W'(lztd_pkg::MIN_MATCH);
		push_cmd.back_dist = token_ch.back_distance;
		push_cmd.lit       = token_ch.literal_byte;
	end

endmodule

`default_nettype wire

/* src/lztd_cmd_fifo.sv */
// Two-entry command queue between the front end and the back end.
`default_nettype none

module lztd_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lztd_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output lztd_pkg::cmd_t      head_cmd,
	output logic                full,
	output logic                not_empty
);

	lztd_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     level_q;

	assign full      = (level_q == 2'd2);
	assign not_empty = (level_q != 2'd0);
	assign head_cmd  = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) level_q <= level_q + 2'd1;
			else if (pop && !push) level_q <= level_q - 2'd1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

/* src/lztd_back.sv */
// Back end: keeps the byte count and history, and emits the decoded bytes.
`default_nettype none

module lztd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lztd_pkg::CNT_W-1:0]    cfg_wdata,
	input  wire logic                          cmd_valid,
	input  wire lztd_pkg::cmd_t                cmd,
	output lztd_pkg::back_stat_t               stat,
	lztd_byte_if.source                        byte_ch
);

	localparam int unsigned AW = lztd_pkg::HIST_AW;
	localparam int unsigned CW = lztd_pkg::CNT_W;

	lztd_pkg::back_state_t state_q, state_d;

	logic [CW-1:0]                 count_q, count_d;
	logic [CW-1:0]                 cap_q;
	logic [lztd_pkg::RUN_W-1:0]    left_q, left_d;
	logic                          copy_ok_q, copy_ok_d;
	logic                          rd_vld_q, rd_vld_d;
	logic [lztd_pkg::DIST_W-1:0]   dist_q;
	logic [lztd_pkg::BYTE_W-1:0]   lit_q;

	// Output register.
	logic                          ob_valid_q;
	logic [lztd_pkg::BYTE_W-1:0]   ob_byte_q;
	logic                          ob_last_q;
	logic                          out_free;

	// History memory ports.
	logic [lztd_pkg::BYTE_W-1:0]   hist_mem [lztd_pkg::HIST_DEPTH];
	logic [lztd_pkg::BYTE_W-1:0]   rdata_q;
	logic                          mem_we, mem_re;
	logic [AW-1:0]                 mem_raddr;
	logic [lztd_pkg::BYTE_W-1:0]   mem_wdata;

	logic                          pop;
	logic                          emit;
	logic [lztd_pkg::BYTE_W-1:0]   emit_byte;
	logic                          emit_last;

	logic [CW-1:0]                 dist_ext;
	logic [CW-1:0]                 src_pos;
	logic [AW-1:0]                 src0;
	logic                          room;

	assign out_free = !ob_valid_q || byte_ch.ready;
	assign dist_ext = CW'(dist_q);
	assign src_pos  = count_q - dist_ext;
	assign src0     = src_pos[AW-1:0];
	assign room     = (count_q < cap_q);

	assign stat.busy = (state_q != lztd_pkg::BK_IDLE);
	assign stat.pop  = pop;

	// Sequencer: next state, memory control and byte emission.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		left_d    = left_q;
		copy_ok_d = copy_ok_q;
		rd_vld_d  = rd_vld_q;
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = src0;
		mem_wdata = rdata_q;
		emit      = 1'b0;
		emit_byte = rdata_q;
		emit_last = 1'b0;

		unique case (state_q)
			lztd_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					pop       = 1'b1;
					left_d    = cmd.copy_len;
					copy_ok_d = cmd.copy_ok;
					if (cmd.start) count_d = '0;
					state_d = lztd_pkg::BK_CHECK;
				end
			end
			lztd_pkg::BK_CHECK: begin
				rd_vld_d = 1'b0;
				if (copy_ok_q && (dist_ext <= count_q)) state_d = lztd_pkg::BK_COPY;
				else state_d = lztd_pkg::BK_LIT;
			end
			lztd_pkg::BK_COPY: begin
				if (!room) begin
					state_d = lztd_pkg::BK_LIT;
				end else if (!rd_vld_q) begin
					mem_re   = 1'b1;
					rd_vld_d = 1'b1;
				end else if (out_free) begin
					// The copied byte is last when it fills the capacity.
					emit      = 1'b1;
					emit_last = (count_q + CW'(1) == cap_q);
					mem_we    = 1'b1;
					count_d   = count_q + CW'(1);
					left_d    = left_q - lztd_pkg::RUN_W'(1);
					if (left_q == lztd_pkg::RUN_W'(1)) begin
						rd_vld_d = 1'b0;
						state_d  = lztd_pkg::BK_LIT;
					end else if (dist_q != lztd_pkg::DIST_W'(1)) begin
						// Fetch the next source byte; at distance one it is the
						// byte just emitted, which the read register still holds.
						mem_re    = 1'b1;
						mem_raddr = src0 + AW'(1);
					end
				end
			end
			lztd_pkg::BK_LIT: begin
				mem_wdata = lit_q;
				emit_byte = lit_q;
				emit_last = 1'b1;
				if (!room) begin
					state_d = lztd_pkg::BK_IDLE;
				end else if (out_free) begin
					emit    = 1'b1;
					mem_we  = 1'b1;
					count_d = count_q + CW'(1);
					state_d = lztd_pkg::BK_IDLE;
				end
			end
			default: state_d = lztd_pkg::BK_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lztd_pkg::BK_IDLE;
			count_q    <= '0;
			cap_q      <= lztd_pkg::CAP_RESET;
			left_q     <= '0;
			copy_ok_q  <= 1'b0;
			rd_vld_q   <= 1'b0;
			ob_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			left_q    <= left_d;
			copy_ok_q <= copy_ok_d;
			rd_vld_q  <= rd_vld_d;
			if (cfg_we) cap_q <= cfg_wdata;
			if (emit) ob_valid_q <= 1'b1;
			else if (byte_ch.ready) ob_valid_q <= 1'b0;
		end
	end

	// Token payload and output payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			dist_q <= cmd.back_dist;
			lit_q  <= cmd.lit;
		end
		if (emit) begin
			ob_byte_q <= emit_byte;
			ob_last_q <= emit_last;
		end
	end

	// History ring: at most one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) hist_mem[count_q[AW-1:0]] <= mem_wdata;
		if (mem_re) rdata_q <= hist_mem[mem_raddr];
	end

	assign byte_ch.valid    = ob_valid_q;
	assign byte_ch.out_byte = ob_byte_q;
	assign byte_ch.run_last = ob_last_q;

endmodule

`default_nettype wire

/* src/lz77_token_decoder_top.sv */
// Top level of the LZ77 token decoder: front end, command queue and back end.
//
// token_ch takes one token per beat (start flag, 12-bit back distance, 4-bit
// length code, literal byte). byte_ch gives one decoded byte per beat, with
// run_last marking the last byte a token produces; a token may produce none.
// cfg_we/cfg_wdata write the output capacity; the user must write it only
// while the block is idle, which the block itself does not enforce.
// A two-entry queue decouples token intake from byte output, so tokens are
// taken while the back end is still expanding an earlier one.
// Each token passes through the queue; the back end takes it in BK_IDLE,
// checks it in BK_CHECK, emits any copied bytes in BK_COPY and then its
// literal in BK_LIT, and every byte leaves through the output register.
// Each copied byte is read from the registered history read port before it
// is emitted, with the just-written byte reused for a distance of one.
// Reset clears the byte count, the queue and the output register, and sets
// the capacity to all ones; the history needs no clearing.
// When the receiver stalls, the output register holds its byte, the back end
// waits, and once the queue fills token_ch.ready falls.
`default_nettype none

module lz77_token_decoder_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [lztd_pkg::CNT_W-1:0]  cfg_wdata,
	lztd_tok_if.sink                         token_ch,
	lztd_byte_if.source                      byte_ch
);

	lztd_pkg::cmd_t       push_cmd;
	lztd_pkg::cmd_t       head_cmd;
	lztd_pkg::back_stat_t bstat;
	logic                 push;
	logic                 q_full;
	logic                 cmd_valid;

	// Token intake and classification.
	lztd_front u_front (
		.token_ch (token_ch),
		.q_full   (q_full),
		.push_cmd (push_cmd),
		.push     (push)
	);

	// Command queue.
	lztd_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (bstat.pop),
		.head_cmd  (head_cmd),
		.full      (q_full),
		.not_empty (cmd_valid)
	);

	// Byte generation.
	lztd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd       (head_cmd),
		.stat      (bstat),
		.byte_ch   (byte_ch)
	);

`ifndef SYNTHESIS
	// The back end never takes a command from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop |-> cmd_valid)
		else $error("command popped from empty queue");

	// An accepted token is in the queue on the next cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(token_ch.valid && token_ch.ready) |=> cmd_valid)
		else $error("accepted token missing from queue");

	// The back end only becomes busy by taking a command.
	a_busy_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(bstat.busy) |-> $past(bstat.pop))
		else $error("back end started without a command");
`endif

endmodule

`default_nettype wire
